[hdl/lpsm_pkg.sv]
// ----------------------------------------------------------------------------
// lpsm_pkg: shared types and constants for the link phase state machine
// Phase, reason, outcome and operation codes; word widths; counter widths.
// ----------------------------------------------------------------------------
package lpsm_pkg;

  localparam int unsigned TimeBits  = 32;
  localparam int unsigned CountBits = 32;
  // width used for the liveness compare: covers both elapsed time and timeout
  localparam int unsigned CmpBits   = (TimeBits > 32) ? TimeBits : 32;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [TimeBits-1:0]  stamp_t;

  // phase held one-hot
  typedef enum logic [5:0] {
    PH_ABSENT     = 6'b000001,
    PH_ATTACHED   = 6'b000010,
    PH_CONNECTING = 6'b000100,
    PH_READY      = 6'b001000,
    PH_FAULTED    = 6'b010000,
    PH_SUSPENDED  = 6'b100000
  } phase_e;

  // phase as reported in the result word
  typedef enum logic [2:0] {
    PC_ABSENT     = 3'd0,
    PC_ATTACHED   = 3'd1,
    PC_CONNECTING = 3'd2,
    PC_READY      = 3'd3,
    PC_FAULTED    = 3'd4,
    PC_SUSPENDED  = 3'd5
  } phase_code_e;

  typedef enum logic [2:0] {
    RS_NONE     = 3'd0,
    RS_UNKNOWN  = 3'd1,
    RS_PEER     = 3'd2,
    RS_LOCAL    = 3'd3,
    RS_FAULT    = 3'd4,
    RS_LIVENESS = 3'd5,
    RS_RESTART  = 3'd6
  } cause_e;

  typedef enum logic [1:0] {
    OC_APPLIED   = 2'd0,
    OC_IGNORED   = 2'd1,
    OC_REDUNDANT = 2'd2,
    OC_TICK_IDLE = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    OP_ATTACH      = 4'd0,
    OP_DETACH      = 4'd1,
    OP_ARRIVING    = 4'd2,
    OP_ESTABLISHED = 4'd3,
    OP_DATA        = 4'd4,
    OP_GONE        = 4'd5,
    OP_CLOSE       = 4'd6,
    OP_FAULT       = 4'd7,
    OP_SUSPEND     = 4'd8,
    OP_RESUME      = 4'd9,
    OP_RESTART     = 4'd10,
    OP_TICK        = 4'd11
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgReqEstablish = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLiveTimeout  = 2'd1;

  function automatic phase_code_e phase_code(phase_e ph);
    phase_code_e code;
    unique case (ph)
      PH_ABSENT:     code = PC_ABSENT;
      PH_ATTACHED:   code = PC_ATTACHED;
      PH_CONNECTING: code = PC_CONNECTING;
      PH_READY:      code = PC_READY;
      PH_FAULTED:    code = PC_FAULTED;
      PH_SUSPENDED:  code = PC_SUSPENDED;
      default:       code = PC_ABSENT;
    endcase
    return code;
  endfunction

endpackage

[hdl/link_phase_state_machine.sv]
// ----------------------------------------------------------------------------
// link_phase_state_machine: transport link phase tracker
// Takes one event or tick word, updates phase and counters, returns one
// result word with the outcome and a snapshot of the link state.
// ----------------------------------------------------------------------------
// One result word per input word, one word per cycle sustained while the
// result side does not stall. An input word is latched into the input
// register, evaluated against the link state once the result register is free
// and written to the result register together with the state update, which
// raises m_axis_tvalid. A stalled result register holds back only the stage
// behind it; the input side keeps one word in hand.
// Configuration writes are always accepted and must only be issued while no
// word is in flight.
module link_phase_state_machine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // operation[3:0], now_time[35:4], cause[38:36], zero pad [39]
  input  logic [lpsm_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // outcome[1:0], phase_now[4:2], epoch_count[36:5], session_count[68:37],
  // ignored_count[100:69], disconnect_cause[103:101]
  output logic [lpsm_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpsm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lpsm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import lpsm_pkg::*;

  // configuration
  logic        req_est_q;
  logic [31:0] timeout_q;

  // input register
  logic               in_vld_q;
  logic [InDataW-1:0] in_data_q;

  // result register
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // link state
  phase_e ph_q, ph_d;
  phase_e pbs_q, pbs_d;
  cause_e cause_q, cause_d;
  stamp_t lat_q, lat_d;
  count_t epoch_q, epoch_d;
  count_t sess_q, sess_d;
  count_t ign_q, ign_d;

  logic advance;

  // decoded input word
  op_e    op;
  stamp_t t_now;
  cause_e why;

  // transition request
  logic     go_en;
  phase_e   go_tgt;
  cause_e   go_why;
  outcome_e oc;

  logic               is_live;
  stamp_t             elapsed;
  logic               timed_out;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign op    = op_e'(in_data_q[3:0]);
  assign t_now = TimeBits'(in_data_q[35:4]);
  assign why   = cause_e'(in_data_q[38:36]);

  assign is_live   = (ph_q == PH_READY) || (ph_q == PH_CONNECTING);
  assign elapsed   = t_now - lat_q;
  assign timed_out = (timeout_q != 32'd0) &&
                     (CmpBits'(elapsed) >= CmpBits'(timeout_q));

  always_comb begin
    ph_d    = ph_q;
    pbs_d   = pbs_q;
    cause_d = cause_q;
    lat_d   = lat_q;
    epoch_d = epoch_q;
    sess_d  = sess_q;
    ign_d   = ign_q;
    go_en   = 1'b0;
    go_tgt  = ph_q;
    go_why  = RS_NONE;
    oc      = OC_APPLIED;

    unique case (op)
      OP_ATTACH: begin
        if (ph_q == PH_ABSENT) begin
          go_en  = 1'b1;
          go_tgt = PH_ATTACHED;
        end else if (ph_q == PH_ATTACHED || is_live) begin
          oc = OC_REDUNDANT;
        end else begin
          oc = OC_IGNORED;
        end
      end
      OP_DETACH: begin
        if (ph_q == PH_ABSENT) begin
          oc = OC_REDUNDANT;
        end else begin
          go_en  = 1'b1;
          go_tgt = PH_ABSENT;
          go_why = why;
        end
      end
      OP_ARRIVING: begin
        if (ph_q == PH_ATTACHED) begin
          go_en  = 1'b1;
          go_tgt = PH_CONNECTING;
        end else begin
          oc = OC_IGNORED;
        end
      end
      OP_ESTABLISHED: begin
        if (ph_q == PH_READY) begin
          oc = OC_REDUNDANT;
        end else if (ph_q == PH_CONNECTING || ph_q == PH_ATTACHED) begin
          go_en  = 1'b1;
          go_tgt = PH_READY;
        end else begin
          oc = OC_IGNORED;
        end
      end
      OP_DATA: begin
        if (ph_q == PH_READY) begin
          lat_d = t_now;
        end else if (!req_est_q && (ph_q == PH_ATTACHED || ph_q == PH_CONNECTING)) begin
          go_en  = 1'b1;
          go_tgt = PH_READY;
        end else begin
          oc = OC_IGNORED;
        end
      end
      OP_GONE: begin
        if (is_live) begin
          go_en  = 1'b1;
          go_tgt = PH_ATTACHED;
          go_why = why;
        end else begin
          oc = OC_IGNORED;
        end
      end
      OP_CLOSE: begin
        if (is_live) begin
          go_en  = 1'b1;
          go_tgt = PH_ATTACHED;
          go_why = RS_LOCAL;
        end else begin
          oc = OC_REDUNDANT;
        end
      end
      OP_FAULT: begin
        go_en  = 1'b1;
        go_tgt = PH_FAULTED;
        go_why = RS_FAULT;
      end
      OP_SUSPEND: begin
        if (ph_q == PH_SUSPENDED) begin
          oc = OC_REDUNDANT;
        end else if (ph_q == PH_ABSENT || ph_q == PH_FAULTED) begin
          oc = OC_IGNORED;
        end else begin
          pbs_d  = ph_q;
          go_en  = 1'b1;
          go_tgt = PH_SUSPENDED;
          go_why = RS_LOCAL;
        end
      end
      OP_RESUME: begin
        if (ph_q == PH_SUSPENDED) begin
          go_en  = 1'b1;
          go_tgt = (pbs_q == PH_ABSENT) ? PH_ABSENT : PH_ATTACHED;
          go_why = RS_LOCAL;
        end else begin
          oc = OC_IGNORED;
        end
      end
      OP_RESTART: begin
        ph_d    = PH_ABSENT;
        pbs_d   = PH_ABSENT;
        cause_d = RS_RESTART;
        lat_d   = '0;
        epoch_d = epoch_q + count_t'(1);
      end
      OP_TICK: begin
        oc = OC_TICK_IDLE;
        if (ph_q == PH_READY && timed_out) begin
          go_en  = 1'b1;
          go_tgt = PH_ATTACHED;
          go_why = RS_LIVENESS;
          oc     = OC_APPLIED;
        end
      end
      default: begin
        oc = OC_IGNORED;
      end
    endcase

    if (oc == OC_IGNORED) begin
      ign_d = ign_q + count_t'(1);
    end

    // phase change: leaving ready ends the epoch, entering ready opens a session
    if (go_en && go_tgt != ph_q) begin
      if (ph_q == PH_READY) begin
        epoch_d = epoch_q + count_t'(1);
        cause_d = (go_why == RS_NONE || go_why > RS_RESTART) ? RS_UNKNOWN : go_why;
      end
      if (go_tgt == PH_READY) begin
        sess_d = sess_q + count_t'(1);
        lat_d  = t_now;
      end
      ph_d = go_tgt;
    end

    out_data_d = {cause_d, 32'(ign_d), 32'(sess_d), 32'(epoch_d),
                  phase_code(ph_d), oc};
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_est_q <= 1'b1;
      timeout_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgReqEstablish) begin
        req_est_q <= cfg_data_i[0];
      end
      if (cfg_index_i == CfgLiveTimeout) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // handshake and link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ph_q      <= PH_ABSENT;
      pbs_q     <= PH_ABSENT;
      cause_q   <= RS_NONE;
      lat_q     <= '0;
      epoch_q   <= '0;
      sess_q    <= '0;
      ign_q     <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        ph_q      <= ph_d;
        pbs_q     <= pbs_d;
        cause_q   <= cause_d;
        lat_q     <= lat_d;
        epoch_q   <= epoch_d;
        sess_q    <= sess_d;
        ign_q     <= ign_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_no_advance_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !advance)
    else $error("result register overwritten while stalled");

  a_ignored_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && oc == OC_IGNORED) |=> (ign_q == $past(ign_q) + count_t'(1)))
    else $error("ignored word not counted");

  a_suspend_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_SUSPENDED) |-> (pbs_q != PH_SUSPENDED && pbs_q != PH_FAULTED))
    else $error("bad phase recorded before suspend");

  a_session_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ph_q != PH_READY && ph_d == PH_READY)
      |=> (sess_q == $past(sess_q) + count_t'(1)))
    else $error("session not counted on entry to ready");
`endif

endmodule

[test/link_phase_state_machine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_phase_state_machine_test: self-checking bench for the link phase tracker
// Drives event and tick words with random gaps and result back-pressure. Each
// accepted word is run through a local model of the phase machine, and every
// result word is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module link_phase_state_machine_test;
  import lpsm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [3:0]  OpSpareLo  = 4'd12;
  localparam logic [3:0]  OpSpareHi  = 4'd15;
  localparam logic [2:0]  CauseSpare = 3'd7;

  typedef struct {
    logic [1:0] outcome;
    logic [2:0] phase;
    count_t     epoch;
    count_t     sessions;
    count_t     ignored;
    logic [2:0] cause;
  } link_snapshot_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // local copy of the link state, starting from its reset values
  phase_code_e link_phase  = PC_ABSENT;
  phase_code_e resume_phase = PC_ABSENT;
  logic [2:0]  why_last    = RS_NONE;
  stamp_t      active_at   = '0;
  count_t      epoch_ctr   = '0;
  count_t      session_ctr = '0;
  count_t      ignore_ctr  = '0;
  logic        req_estab   = 1'b1;
  logic [31:0] live_tmo    = '0;

  link_snapshot_t link_snapshots_due[$];
  link_snapshot_t head;
  stamp_t         clock_now = '0;
  bit             steady = 1'b0;
  int             fail_count = 0;
  int             cycle_count = 0;

  link_phase_state_machine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // phase model
  // ------------------------------------------------------------------------
  function automatic void move_to(phase_code_e target, stamp_t t, logic [2:0] why);
    if (target == link_phase) return;
    if (link_phase == PC_READY) begin
      epoch_ctr++;
      why_last = (why == RS_NONE || why > RS_RESTART) ? RS_UNKNOWN : why;
    end
    if (target == PC_READY) begin
      session_ctr++;
      active_at = t;
    end
    link_phase = target;
  endfunction

  function automatic outcome_e count_ignored();
    ignore_ctr++;
    return OC_IGNORED;
  endfunction

  function automatic bit link_live();
    return link_phase == PC_READY || link_phase == PC_CONNECTING;
  endfunction

  function automatic link_snapshot_t advance_link(logic [3:0] op, stamp_t t,
                                                  logic [2:0] why);
    outcome_e       oc;
    stamp_t         elapsed;
    link_snapshot_t snap;
    oc = OC_APPLIED;
    case (op)
      OP_ATTACH:
        if (link_phase == PC_ABSENT) move_to(PC_ATTACHED, t, RS_NONE);
        else if (link_phase == PC_ATTACHED || link_live()) oc = OC_REDUNDANT;
        else oc = count_ignored();
      OP_DETACH:
        if (link_phase == PC_ABSENT) oc = OC_REDUNDANT;
        else move_to(PC_ABSENT, t, why);
      OP_ARRIVING:
        if (link_phase != PC_ATTACHED) oc = count_ignored();
        else move_to(PC_CONNECTING, t, RS_NONE);
      OP_ESTABLISHED:
        if (link_phase == PC_READY) oc = OC_REDUNDANT;
        else if (link_phase != PC_CONNECTING && link_phase != PC_ATTACHED)
          oc = count_ignored();
        else move_to(PC_READY, t, RS_NONE);
      OP_DATA:
        if (link_phase == PC_READY) active_at = t;
        else if (!req_estab && (link_phase == PC_ATTACHED || link_phase == PC_CONNECTING))
          move_to(PC_READY, t, RS_NONE);
        else oc = count_ignored();
      OP_GONE:
        if (!link_live()) oc = count_ignored();
        else move_to(PC_ATTACHED, t, why);
      OP_CLOSE:
        if (!link_live()) oc = OC_REDUNDANT;
        else move_to(PC_ATTACHED, t, RS_LOCAL);
      OP_FAULT:
        move_to(PC_FAULTED, t, RS_FAULT);
      OP_SUSPEND:
        if (link_phase == PC_SUSPENDED) oc = OC_REDUNDANT;
        else if (link_phase == PC_ABSENT || link_phase == PC_FAULTED) oc = count_ignored();
        else begin
          resume_phase = link_phase;
          move_to(PC_SUSPENDED, t, RS_LOCAL);
        end
      OP_RESUME:
        if (link_phase != PC_SUSPENDED) oc = count_ignored();
        else move_to((resume_phase == PC_ABSENT) ? PC_ABSENT : PC_ATTACHED, t, RS_LOCAL);
      OP_RESTART: begin
        link_phase   = PC_ABSENT;
        resume_phase = PC_ABSENT;
        why_last     = RS_RESTART;
        active_at    = '0;
        epoch_ctr++;
      end
      OP_TICK: begin
        oc = OC_TICK_IDLE;
        elapsed = t - active_at;
        if (link_phase == PC_READY && live_tmo != 0 && elapsed >= live_tmo) begin
          move_to(PC_ATTACHED, t, RS_LIVENESS);
          oc = OC_APPLIED;
        end
      end
      default:
        oc = count_ignored();
    endcase
    snap.outcome  = oc;
    snap.phase    = link_phase;
    snap.epoch    = epoch_ctr;
    snap.sessions = session_ctr;
    snap.ignored  = ignore_ctr;
    snap.cause    = why_last;
    return snap;
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (link_snapshots_due.size() == 0) begin
        $error("result word with no prediction pending");
        fail_count++;
      end else begin
        head = link_snapshots_due.pop_front();
        check_field("outcome", 32'(head.outcome), 32'(m_axis_tdata[1:0]));
        check_field("phase_now", 32'(head.phase), 32'(m_axis_tdata[4:2]));
        check_field("epoch_count", head.epoch, m_axis_tdata[36:5]);
        check_field("session_count", head.sessions, m_axis_tdata[68:37]);
        check_field("ignored_count", head.ignored, m_axis_tdata[100:69]);
        check_field("disconnect_cause", 32'(head.cause), 32'(m_axis_tdata[103:101]));
      end
    end
  end

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // result side back-pressure
  initial begin
    int hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = idle_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // valid is left high after acceptance; the next word or wait_idle moves it
  task automatic send_word(logic [3:0] op, stamp_t t, logic [2:0] why);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, why, t, op};
    do @(posedge clk_i); while (!s_axis_tready);
    link_snapshots_due.push_back(advance_link(op, t, why));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (link_snapshots_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers in one burst, valid held high across the pair
  task automatic set_config(logic req, logic [31:0] tmo);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgReqEstablish;
    cfg_data_i  <= {31'b0, req};
    do @(posedge clk_i); while (!cfg_ready_o);
    req_estab = req;
    cfg_index_i <= CfgLiveTimeout;
    cfg_data_i  <= tmo;
    do @(posedge clk_i); while (!cfg_ready_o);
    live_tmo = tmo;
    cfg_valid_i <= 1'b0;
  endtask

  // mostly the moves that make sense from the current phase, some noise
  function automatic logic [3:0] pick_op();
    logic [3:0] menu[$];
    if ($urandom_range(0, 99) < 12) return 4'($urandom_range(0, 15));
    case (link_phase)
      PC_ABSENT:     menu = '{OP_ATTACH, OP_ATTACH, OP_ATTACH, OP_RESTART, OP_TICK};
      PC_ATTACHED:   menu = '{OP_ARRIVING, OP_ARRIVING, OP_ESTABLISHED, OP_DATA,
                              OP_TICK, OP_DETACH, OP_SUSPEND};
      PC_CONNECTING: menu = '{OP_ESTABLISHED, OP_ESTABLISHED, OP_DATA, OP_GONE,
                              OP_CLOSE, OP_TICK};
      PC_READY:      menu = '{OP_DATA, OP_DATA, OP_TICK, OP_TICK, OP_TICK, OP_GONE,
                              OP_CLOSE, OP_FAULT, OP_SUSPEND, OP_DETACH, OP_ESTABLISHED};
      PC_FAULTED:    menu = '{OP_DETACH, OP_RESTART, OP_FAULT, OP_ATTACH};
      default:       menu = '{OP_RESUME, OP_RESUME, OP_SUSPEND, OP_DETACH};
    endcase
    return menu[$urandom_range(0, menu.size() - 1)];
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 4) clock_now = $urandom();
      else clock_now = clock_now + $urandom_range(0, 3);
      send_word(pick_op(), clock_now, 3'($urandom_range(0, 7)));
      // hold the sender off now and then until everything is back
      if (n % 40 == 39) wait_idle();
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_directed_walk();
    send_word(OP_TICK, 32'd0, RS_NONE);
    send_word(OpSpareHi, 32'hFFFF_FFFF, CauseSpare);
    send_word(OpSpareLo, 32'd1, RS_NONE);
    send_word(OP_ATTACH, 32'd2, RS_NONE);
    send_word(OP_ATTACH, 32'd3, RS_NONE);
    send_word(OP_ARRIVING, 32'd4, RS_NONE);
    send_word(OP_ESTABLISHED, 32'hFFFF_FFFF, RS_NONE);
    send_word(OP_DATA, 32'd0, RS_NONE);
    send_word(OP_GONE, 32'd1, CauseSpare);       // undefined reason -> unknown
    send_word(OP_DATA, 32'd2, RS_NONE);          // establishment required
    send_word(OP_ESTABLISHED, 32'd3, RS_NONE);
    send_word(OP_CLOSE, 32'd4, RS_PEER);
    send_word(OP_FAULT, 32'd5, RS_NONE);
    send_word(OP_FAULT, 32'd6, RS_NONE);         // already faulted
    send_word(OP_SUSPEND, 32'd7, RS_NONE);
    send_word(OP_DETACH, 32'd8, RS_PEER);
    send_word(OP_DETACH, 32'd9, RS_PEER);
    send_word(OP_RESUME, 32'd10, RS_NONE);
    send_word(OP_ATTACH, 32'd11, RS_NONE);
    send_word(OP_SUSPEND, 32'd12, RS_NONE);
    send_word(OP_SUSPEND, 32'd13, RS_NONE);
    send_word(OP_RESUME, 32'd14, RS_NONE);
    send_word(OP_RESTART, 32'd15, RS_RESTART);
  endtask

  task automatic test_liveness_drop();
    wait_idle();
    set_config(1'b0, 32'd5);
    send_word(OP_ATTACH, 32'd0, RS_NONE);
    send_word(OP_DATA, 32'hFFFF_FFFE, RS_NONE);  // data promotes to ready
    send_word(OP_TICK, 32'd2, RS_NONE);          // elapsed wraps to 4
    send_word(OP_TICK, 32'd3, RS_NONE);          // elapsed 5: drop
    send_word(OP_DATA, 32'd4, RS_NONE);
    send_word(OP_DETACH, 32'd5, RS_NONE);        // no reason -> unknown
    wait_idle();
    set_config(1'b1, 32'hFFFF_FFFF);
    send_word(OP_ATTACH, 32'd90, RS_NONE);
    send_word(OP_ESTABLISHED, 32'd100, RS_NONE);
    send_word(OP_TICK, 32'd98, RS_NONE);
    send_word(OP_TICK, 32'd99, RS_NONE);
  endtask

  task automatic test_random_phases();
    logic [31:0] timeouts[6];
    logic        reqs[6];
    timeouts = '{32'd0, 32'd3, 32'd7, 32'hFFFF_FFFF, $urandom_range(1, 20), 32'd1};
    reqs     = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      set_config(reqs[p], timeouts[p]);
      send_random(75);
    end
  endtask

  task automatic test_back_to_back();
    wait_idle();
    set_config(1'b0, $urandom_range(2, 10));
    steady = 1'b1;
    send_random(39);
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_walk();
    test_liveness_drop();
    test_random_phases();
    test_back_to_back();
    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lpsm_pkg.sv
hdl/link_phase_state_machine.sv
test/link_phase_state_machine_test.sv
